[rtl/lzo_pkg.sv]
// Package for the layer z-order stack.
// Shared constants, index types and the order store port struct.
// No dependencies.
`timescale 1ns / 1ps

package lzo_pkg;

  localparam int MAX_LAYERS = 16;
  localparam int LIST_LIMIT = 16;

  localparam int IDX_W  = $clog2(MAX_LAYERS);
  localparam int CNT_W  = $clog2(MAX_LAYERS + 1);
  localparam int ID_W   = 5;
  localparam int HGT_W  = 6;
  localparam int SLOT_W = 4;
  localparam int CMP_W  = (CNT_W > HGT_W) ? CNT_W : HGT_W;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ID_W-1:0]  ident_t;

  typedef struct packed {
    logic   we;
    idx_t   waddr;
    ident_t wdata;
    logic   re;
    idx_t   raddr;
  } mem_req_t;

endpackage

[rtl/lzo_if.sv]
// Valid/ready channel interfaces for requests and listing results.
// Depends on lzo_pkg.
`timescale 1ns / 1ps

interface lzo_req_if;
  logic                          valid;
  logic                          ready;
  lzo_pkg::ident_t               layer_ident;
  logic signed [lzo_pkg::HGT_W-1:0] target_height;

  modport source (output valid, output layer_ident, output target_height, input ready);
  modport sink   (input valid, input layer_ident, input target_height, output ready);
endinterface

interface lzo_res_if;
  logic                        valid;
  logic                        ready;
  logic [lzo_pkg::SLOT_W-1:0]  slot_index;
  lzo_pkg::ident_t             slot_layer;
  logic                        last_slot;
  logic                        stack_empty;

  modport source (output valid, output slot_index, output slot_layer, output last_slot,
                  output stack_empty, input ready);
  modport sink   (input valid, input slot_index, input slot_layer, input last_slot,
                  input stack_empty, output ready);
endinterface

[rtl/lzo_store.sv]
// Order store: one write port, one read port with registered read data.
// Read data holds until the next read. Depends on lzo_pkg.
`timescale 1ns / 1ps

module lzo_store (
  input  logic              clk_i,
  input  lzo_pkg::mem_req_t req_i,
  output lzo_pkg::ident_t   rd_data_o
);

  lzo_pkg::ident_t mem [lzo_pkg::MAX_LAYERS];
  lzo_pkg::ident_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rd_data_q <= mem[req_i.raddr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/lzo_seq.sv]
// Sequencer: scan, shift, place and listing over the order store, plus the
// result register. Depends on lzo_pkg and lzo_if.
`timescale 1ns / 1ps

module lzo_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  lzo_req_if.sink           req_i,
  lzo_res_if.source         res_o,
  output lzo_pkg::mem_req_t mem_o,
  input  lzo_pkg::ident_t   rd_data_i
);

  typedef enum logic [2:0] {
    IDLE, FIND, DECIDE, SHIFT, SHIFT_END, PLACE, LIST_START, LIST
  } state_e;

  typedef struct packed {
    logic              shift;
    logic              up;
    lzo_pkg::idx_t     src;
    lzo_pkg::idx_t     last;
    logic              wr;
    lzo_pkg::idx_t     place;
    lzo_pkg::cnt_t     cnt_new;
  } plan_t;

  state_e                           state_q;
  lzo_pkg::ident_t                  ident_q;
  logic [lzo_pkg::HGT_W-1:0]        hgt_q;
  lzo_pkg::cnt_t                    cnt_q;
  lzo_pkg::cnt_t                    scan_q;
  logic                             rd_vld_q;
  lzo_pkg::idx_t                    rd_addr_q;
  lzo_pkg::idx_t                    pos_q;
  logic                             present_q;
  logic                             up_q;
  lzo_pkg::idx_t                    src_q;
  lzo_pkg::idx_t                    last_q;
  logic                             wr_q;
  lzo_pkg::idx_t                    place_q;
  lzo_pkg::cnt_t                    cnt_new_q;
  lzo_pkg::idx_t                    k_q;
  lzo_pkg::cnt_t                    listed_q;
  logic                             out_vld_q;
  logic [lzo_pkg::SLOT_W-1:0]       out_idx_q;
  lzo_pkg::ident_t                  out_layer_q;
  logic                             out_last_q;
  logic                             out_empty_q;

  logic              accept;
  logic              id_ok;
  logic              match;
  logic              out_free;
  logic              list_last;
  lzo_pkg::cnt_t     listed_d;
  lzo_pkg::cnt_t     hc;
  lzo_pkg::cnt_t     hp;
  lzo_pkg::cnt_t     posc;
  logic [lzo_pkg::CMP_W-1:0] hu;
  plan_t             plan;
  lzo_pkg::mem_req_t mem;

  assign req_i.ready = (state_q == IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign id_ok       = (req_i.layer_ident != '0) &&
                       (int'(req_i.layer_ident) <= lzo_pkg::MAX_LAYERS);
  assign match       = rd_vld_q && (rd_data_i == ident_q);
  assign out_free    = !out_vld_q || res_o.ready;
  assign list_last   = ((lzo_pkg::CNT_W'(k_q) + 1'b1) == listed_q);
  assign listed_d    = (int'(cnt_q) < lzo_pkg::LIST_LIMIT) ? cnt_q
                                                           : lzo_pkg::CNT_W'(lzo_pkg::LIST_LIMIT);

  // clamp of the target height and the resulting move plan
  always_comb begin
    hu   = lzo_pkg::CMP_W'(hgt_q[lzo_pkg::HGT_W-2:0]);
    hc   = (hu > lzo_pkg::CMP_W'(cnt_q)) ? cnt_q : lzo_pkg::CNT_W'(hu);
    hp   = (hc == cnt_q) ? cnt_q - 1'b1 : hc;
    posc = lzo_pkg::CNT_W'(pos_q);
    plan = '0;
    plan.cnt_new = cnt_q;
    if (hgt_q[lzo_pkg::HGT_W-1]) begin
      if (present_q) begin
        plan.cnt_new = cnt_q - 1'b1;
        if (posc + 1'b1 < cnt_q) begin
          plan.shift = 1'b1;
          plan.src   = lzo_pkg::IDX_W'(posc + 1'b1);
          plan.last  = lzo_pkg::IDX_W'(cnt_q - 1'b1);
        end
      end
    end else if (!present_q) begin
      if (cnt_q != lzo_pkg::CNT_W'(lzo_pkg::MAX_LAYERS)) begin
        plan.cnt_new = cnt_q + 1'b1;
        plan.wr      = 1'b1;
        plan.place   = lzo_pkg::IDX_W'(hc);
        if (hc < cnt_q) begin
          plan.shift = 1'b1;
          plan.up    = 1'b1;
          plan.src   = lzo_pkg::IDX_W'(cnt_q - 1'b1);
          plan.last  = lzo_pkg::IDX_W'(hc);
        end
      end
    end else begin
      plan.wr    = 1'b1;
      plan.place = lzo_pkg::IDX_W'(hp);
      if (posc < hp) begin
        plan.shift = 1'b1;
        plan.src   = lzo_pkg::IDX_W'(posc + 1'b1);
        plan.last  = lzo_pkg::IDX_W'(hp);
      end else if (posc > hp) begin
        plan.shift = 1'b1;
        plan.up    = 1'b1;
        plan.src   = lzo_pkg::IDX_W'(posc - 1'b1);
        plan.last  = lzo_pkg::IDX_W'(hp);
      end
    end
  end

  // store port
  always_comb begin
    mem = '0;
    unique case (state_q) inside
      FIND: begin
        if (!match && (scan_q != cnt_q)) begin
          mem.re    = 1'b1;
          mem.raddr = lzo_pkg::IDX_W'(scan_q);
        end
      end
      SHIFT, SHIFT_END: begin
        if (state_q == SHIFT) begin
          mem.re    = 1'b1;
          mem.raddr = src_q;
        end
        if (rd_vld_q) begin
          mem.we    = 1'b1;
          mem.waddr = up_q ? rd_addr_q + 1'b1 : rd_addr_q - 1'b1;
          mem.wdata = rd_data_i;
        end
      end
      PLACE: begin
        mem.we    = wr_q;
        mem.waddr = place_q;
        mem.wdata = ident_q;
      end
      LIST_START: begin
        mem.re = (cnt_q != '0);
      end
      LIST: begin
        if (out_free && !list_last) begin
          mem.re    = 1'b1;
          mem.raddr = k_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mem_o = mem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= IDLE;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= mem.re;
      if (mem.re) begin
        rd_addr_q <= mem.raddr;
      end
      if (out_vld_q && res_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        IDLE: begin
          if (accept) begin
            ident_q <= req_i.layer_ident;
            hgt_q   <= req_i.target_height;
            scan_q  <= '0;
            state_q <= id_ok ? FIND : LIST_START;
          end
        end
        FIND: begin
          if (match) begin
            pos_q     <= rd_addr_q;
            present_q <= 1'b1;
            state_q   <= DECIDE;
          end else if (scan_q == cnt_q) begin
            pos_q     <= '0;
            present_q <= 1'b0;
            state_q   <= DECIDE;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        DECIDE: begin
          up_q      <= plan.up;
          src_q     <= plan.src;
          last_q    <= plan.last;
          wr_q      <= plan.wr;
          place_q   <= plan.place;
          cnt_new_q <= plan.cnt_new;
          state_q   <= plan.shift ? SHIFT : PLACE;
        end
        SHIFT: begin
          if (src_q == last_q) begin
            state_q <= SHIFT_END;
          end else begin
            src_q <= up_q ? src_q - 1'b1 : src_q + 1'b1;
          end
        end
        SHIFT_END: begin
          state_q <= PLACE;
        end
        PLACE: begin
          cnt_q   <= cnt_new_q;
          state_q <= LIST_START;
        end
        LIST_START: begin
          if (cnt_q == '0) begin
            if (out_free) begin
              out_vld_q   <= 1'b1;
              out_idx_q   <= '0;
              out_layer_q <= '0;
              out_last_q  <= 1'b1;
              out_empty_q <= 1'b1;
              state_q     <= IDLE;
            end
          end else begin
            k_q      <= '0;
            listed_q <= listed_d;
            state_q  <= LIST;
          end
        end
        LIST: begin
          if (out_free) begin
            out_vld_q   <= 1'b1;
            out_idx_q   <= lzo_pkg::SLOT_W'(k_q);
            out_layer_q <= rd_data_i;
            out_last_q  <= list_last;
            out_empty_q <= 1'b0;
            if (list_last) begin
              state_q <= IDLE;
            end else begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: state_q <= IDLE;
      endcase
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.slot_index  = out_idx_q;
  assign res_o.slot_layer  = out_layer_q;
  assign res_o.last_slot   = out_last_q;
  assign res_o.stack_empty = out_empty_q;

endmodule

[rtl/layer_z_order_stack.sv]
// Top level of the layer z-order stack: sequencer and order store.
// Depends on lzo_pkg, lzo_if, lzo_store and lzo_seq.
//
// Usage:
//   req_i carries one request transaction: layer_ident and a signed
//   target_height (negative hides the layer). res_o returns the full
//   bottom-to-top order, one transaction per shown layer with slot_index,
//   slot_layer and last_slot on the topmost; an empty stack gives a single
//   transaction with stack_empty and last_slot set.
//   A request scans the order store for the layer, shifts the entries
//   between its old and new slot, writes it into its slot unless it is
//   hidden and then lists the stack; an unknown layer goes straight to
//   the listing. The order store moves one entry a cycle while shifting.
//   req_i.ready is high only between requests; the final result may still
//   sit in the output register when the next request is taken.
//   A stalled receiver holds the current result and pauses the listing.
//   Reset empties the stack; the order store needs no clearing.
`timescale 1ns / 1ps

module layer_z_order_stack (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzo_req_if.sink   req_i,
  lzo_res_if.source res_o
);

  lzo_pkg::mem_req_t mem_req;
  lzo_pkg::ident_t   rd_data;

  lzo_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .res_o     (res_o),
    .mem_o     (mem_req),
    .rd_data_i (rd_data)
  );

  lzo_store u_store (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

endmodule

[rtl/lzo_checker.sv]
// Port-level checks for the layer z-order stack, bound to the top level.
// Depends on lzo_pkg and layer_z_order_stack.
`timescale 1ns / 1ps

module lzo_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       res_valid_i,
  input logic                       res_ready_i,
  input logic [lzo_pkg::SLOT_W-1:0] slot_index_i,
  input lzo_pkg::ident_t            slot_layer_i,
  input logic                       last_slot_i,
  input logic                       stack_empty_i
);

  // no new request mid-listing
  a_busy_listing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !last_slot_i |-> !req_ready_i)
    else $error("request taken during a listing");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready straight after a request");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && stack_empty_i |-> last_slot_i && (slot_layer_i == '0) &&
                                     (slot_index_i == '0))
    else $error("malformed empty result");

  a_layer_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !stack_empty_i |-> (slot_layer_i != '0))
    else $error("listed slot holds no layer");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(slot_index_i) &&
      $stable(slot_layer_i) && $stable(last_slot_i) && $stable(stack_empty_i))
    else $error("stalled result changed");

endmodule

bind layer_z_order_stack lzo_checker u_lzo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .res_valid_i   (res_o.valid),
  .res_ready_i   (res_o.ready),
  .slot_index_i  (res_o.slot_index),
  .slot_layer_i  (res_o.slot_layer),
  .last_slot_i   (res_o.last_slot),
  .stack_empty_i (res_o.stack_empty)
);

[verif/tb_layer_z_order_stack.sv]
// Testbench for layer_z_order_stack: directed table, then random requests with random
// idling on both channels; every listing transaction is checked against a z-order predictor.
// Depends on lzo_pkg, lzo_if and the layer_z_order_stack RTL.
`timescale 1ns / 1ps

module tb_layer_z_order_stack;

  localparam int RANDOM_ITEMS   = 93;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_STALL      = 12;

  typedef struct packed {
    logic [lzo_pkg::SLOT_W-1:0] slot_index;
    lzo_pkg::ident_t            slot_layer;
    logic                       last_slot;
    logic                       stack_empty;
  } slot_entry_t;

  typedef struct packed {
    lzo_pkg::ident_t           ident;
    logic [lzo_pkg::HGT_W-1:0] height;
    logic                      empty_only;
  } stim_row_t;

  localparam slot_entry_t EMPTY_LISTING = '{'0, '0, 1'b1, 1'b1};

  // empty_only rows expect the single empty-stack transaction
  localparam int N_DIRECTED = 27;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{5'd1,  -6'sd1,  1'b1},
    '{5'd0,  6'sd0,   1'b1},
    '{5'd17, 6'sd5,   1'b1},
    '{5'd31, 6'sd31,  1'b1},
    '{5'd1,  6'sd0,   1'b0},
    '{5'd2,  6'sd16,  1'b0},
    '{5'd3,  6'sd0,   1'b0},
    '{5'd3,  6'sd31,  1'b0},
    '{5'd2,  6'sd0,   1'b0},
    '{5'd2,  -6'sd32, 1'b0},
    '{5'd5,  -6'sd1,  1'b0},
    '{5'd2,  6'sd1,   1'b0},
    '{5'd4,  6'sd0,   1'b0},
    '{5'd5,  6'sd16,  1'b0},
    '{5'd6,  6'sd3,   1'b0},
    '{5'd7,  6'sd2,   1'b0},
    '{5'd8,  6'sd7,   1'b0},
    '{5'd9,  6'sd0,   1'b0},
    '{5'd10, 6'sd9,   1'b0},
    '{5'd11, 6'sd4,   1'b0},
    '{5'd12, 6'sd16,  1'b0},
    '{5'd13, 6'sd6,   1'b0},
    '{5'd14, 6'sd1,   1'b0},
    '{5'd15, 6'sd13,  1'b0},
    '{5'd16, 6'sd16,  1'b0},
    '{5'd16, 6'sd0,   1'b0},
    '{5'd1,  -6'sd1,  1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  lzo_req_if req_if ();
  lzo_res_if res_if ();

  layer_z_order_stack DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  lzo_pkg::ident_t layer_order [lzo_pkg::MAX_LAYERS];
  int              shown_layers = 0;
  slot_entry_t     pending_slots_q [$];
  int              fault_count = 0;

  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < shown_layers; i++) layer_order[i] = layer_order[i + 1];
    shown_layers--;
  endfunction

  // returns 1 when the request hides, moves or inserts a layer
  function automatic bit restack_layers(lzo_pkg::ident_t id,
                                        logic signed [lzo_pkg::HGT_W-1:0] hgt);
    int pos;
    int tgt;
    pos = shown_layers;
    if (id < 1 || id > lzo_pkg::MAX_LAYERS) return 1'b0;
    for (int i = shown_layers - 1; i >= 0; i--) if (layer_order[i] == id) pos = i;
    if (hgt < 0) begin
      if (pos == shown_layers) return 1'b0;
      drop_slot(pos);
      return 1'b1;
    end
    tgt = (int'(hgt) > shown_layers) ? shown_layers : int'(hgt);
    if (pos < shown_layers) begin
      if (tgt == shown_layers) tgt--;
      drop_slot(pos);
    end else if (shown_layers >= lzo_pkg::MAX_LAYERS) begin
      return 1'b0;
    end
    for (int i = shown_layers; i > tgt; i--) layer_order[i] = layer_order[i - 1];
    layer_order[tgt] = id;
    shown_layers++;
    return 1'b1;
  endfunction

  function automatic void queue_listing();
    int n;
    n = (shown_layers < lzo_pkg::LIST_LIMIT) ? shown_layers : lzo_pkg::LIST_LIMIT;
    if (n == 0) pending_slots_q.push_back(EMPTY_LISTING);
    for (int k = 0; k < n; k++)
      pending_slots_q.push_back(slot_entry_t'{lzo_pkg::SLOT_W'(k), layer_order[k],
                                              (k + 1 == n), 1'b0});
  endfunction

  function automatic void report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endfunction

  task automatic send_request(input lzo_pkg::ident_t id,
                              input logic [lzo_pkg::HGT_W-1:0] hgt,
                              input bit empty_only, input int gap);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.layer_ident   <= id;
    req_if.target_height <= hgt;
    do @(posedge clk_i); while (!req_if.ready);
    void'(restack_layers(id, hgt));
    if (empty_only) pending_slots_q.push_back(EMPTY_LISTING);
    else queue_listing();
  endtask

  initial begin : request_driver
    int              done_items;
    int              n;
    int              hide_pct;
    int              h;
    int              gap;
    bit              burst;
    lzo_pkg::ident_t id;
    done_items = 0;
    n          = 0;
    hide_pct   = 20;
    burst      = 1'b0;
    req_if.valid         <= 1'b0;
    req_if.layer_ident   <= '0;
    req_if.target_height <= '0;
    rst_ni               <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      gap = (i < 8) ? 0 : $urandom_range(0, MAX_STALL);
      send_request(DIRECTED[i].ident, DIRECTED[i].height, DIRECTED[i].empty_only, gap);
    end

    while (done_items < RANDOM_ITEMS) begin
      if (n % 30 == 0) begin
        hide_pct = $urandom_range(5, 70);
        burst    = ($urandom_range(0, 3) == 0);
      end
      n++;
      if ($urandom_range(0, 9) != 0) begin
        id = lzo_pkg::ident_t'($urandom_range(1, lzo_pkg::MAX_LAYERS));
      end else begin
        h  = $urandom_range(lzo_pkg::MAX_LAYERS, 31);
        id = (h == lzo_pkg::MAX_LAYERS) ? lzo_pkg::ident_t'(0) : lzo_pkg::ident_t'(h);
      end
      if ($urandom_range(0, 99) < hide_pct) begin
        h = ($urandom_range(0, 3) == 0) ? -int'($urandom_range(1, 32)) : -1;
      end else if ($urandom_range(0, 9) == 0) begin
        h = $urandom_range(17, 31);
      end else begin
        h = $urandom_range(0, 16);
      end
      gap = burst ? 0 : $urandom_range(0, MAX_STALL);
      send_request(id, lzo_pkg::HGT_W'(h), 1'b0, gap);
      done_items++;
    end
    req_if.valid <= 1'b0;

    while (pending_slots_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("layer_z_order_stack verification clean");
    end else begin
      $display("layer_z_order_stack verification failed");
    end
    $finish;
  end

  initial begin : listing_sink
    int          stall;
    int          seen;
    bit          no_stall;
    slot_entry_t got;
    slot_entry_t want;
    seen     = 0;
    no_stall = 1'b0;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (seen % 40 == 0) no_stall = ($urandom_range(0, 3) == 0);
      stall = no_stall ? 0 : $urandom_range(0, MAX_STALL);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(rst_ni && res_if.valid && res_if.ready));
      seen++;
      got = '{res_if.slot_index, res_if.slot_layer, res_if.last_slot, res_if.stack_empty};
      if (pending_slots_q.size() == 0) begin
        report_fault($sformatf("unexpected transaction: idx %0d layer %0d last %0b empty %0b",
                               got.slot_index, got.slot_layer, got.last_slot, got.stack_empty));
      end else begin
        want = pending_slots_q.pop_front();
        if (got.slot_index !== want.slot_index || got.slot_layer !== want.slot_layer ||
            got.last_slot !== want.last_slot || got.stack_empty !== want.stack_empty)
          report_fault($sformatf(
            "mismatch: exp idx/layer/last/empty %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
            want.slot_index, want.slot_layer, want.last_slot, want.stack_empty,
            got.slot_index, got.slot_layer, got.last_slot, got.stack_empty));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("layer_z_order_stack verification failed");
    $finish;
  end

endmodule
